[rtl/core/bsmo_pkg.sv]
// ----------------------------------------------------------------------------
// bsmo_pkg: shared types and constants of the bus snoop memory overlay
// Item and result layouts, memory write requests, opcodes, ports and
// fixed shadow cell offsets inside the work RAM.
// ----------------------------------------------------------------------------
package bsmo_pkg;

    // memory geometry
    localparam int RAM_BYTES       = 8192;
    localparam int ROM_BYTES       = 8192;
    localparam int MEM_AW          = $clog2(RAM_BYTES);
    localparam int NMI_HOLD_CYCLES = 16;
    localparam int NMI_W           = 5;
    localparam int ROM_LEN_W       = 14;
    localparam int CFG_DATA_W      = 14;

    // item opcodes
    localparam logic [1:0] OP_BUS  = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // configuration register indexes
    localparam logic CFG_PLUGGED    = 1'b0;
    localparam logic CFG_ROM_LENGTH = 1'b1;

    // paging ports
    localparam logic [15:0] PORT_PAGE_IN  = 16'hFEE8;
    localparam logic [15:0] PORT_PAGE_OUT = 16'hFEEA;

    // shadow cells, as offsets into the work RAM
    localparam logic [MEM_AW-1:0] CELL_PEN      = 13'h1FCF;
    localparam logic [MEM_AW-1:0] CELL_INK      = 13'h1FEF;
    localparam logic [MEM_AW-1:0] CELL_GA_CFG   = 13'h1FFF;
    localparam logic [MEM_AW-1:0] CELL_RAM_CFG  = 13'h17FF;
    localparam logic [MEM_AW-1:0] CELL_CRTC_SEL = 13'h1CFF;
    localparam logic [MEM_AW-1:0] CELL_CRTC_REG = 13'h1DB0;
    localparam logic [MEM_AW-1:0] CELL_ROM_SEL  = 13'h1AAC;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data_in;
        logic        machine_reset;
        logic        io_request;
        logic        opcode_fetch;
        logic        write_strobe;
        logic        read_strobe;
        logic        memory_request;
        logic        refresh;
    } t_item;

    typedef struct packed {
        logic       nmi_drive;
        logic       rom_disable;
        logic       ram_disable;
        logic       data_valid;
        logic [7:0] data_out;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

endpackage

[rtl/core/bsmo_ram.sv]
// ----------------------------------------------------------------------------
// bsmo_ram: 8K x 8 single-port-write, single-port-read memory
// Registered read with bypass of a write that lands on the read address
// in the same cycle, so the read sees the newest byte.
// ----------------------------------------------------------------------------
module bsmo_ram (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [bsmo_pkg::MEM_AW-1:0]  i_rd_addr,
    input  bsmo_pkg::t_mem_wr            i_wr,
    output logic [7:0]                   o_rd_data
);

    logic [7:0] r_mem [bsmo_pkg::RAM_BYTES];
    logic [7:0] r_q;
    logic       r_fwd_hit;
    logic [7:0] r_fwd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port with same-cycle write bypass
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

[rtl/core/bsmo_engine.sv]
// ----------------------------------------------------------------------------
// bsmo_engine: per-beat decode, paging state and shadow cells
// Works on the item in the input register with the bytes read from the
// memories, updates paging, NMI hold and shadow cells, and forms the result.
// ----------------------------------------------------------------------------
module bsmo_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  bsmo_pkg::t_item                    i_item,
    input  logic [7:0]                         i_ram_q,
    input  logic [7:0]                         i_rom_q,
    input  logic                               i_plugged,
    input  logic [bsmo_pkg::ROM_LEN_W-1:0]     i_rom_length,
    output bsmo_pkg::t_result                  o_result,
    output bsmo_pkg::t_mem_wr                  o_ram_wr,
    output bsmo_pkg::t_mem_wr                  o_rom_wr
);

    // paging and bus state
    logic                       r_paged, n_paged;
    logic                       r_hidden, n_hidden;
    logic                       r_freeze, n_freeze;
    logic                       r_last_io_wr, n_last_io_wr;
    logic [bsmo_pkg::NMI_W-1:0] r_nmi_left, n_nmi_left;

    // shadow cells kept in flops
    logic [7:0] r_pen, n_pen;
    logic [7:0] r_ink, n_ink;
    logic [7:0] r_ga_cfg, n_ga_cfg;
    logic [7:0] r_ram_cfg, n_ram_cfg;
    logic [7:0] r_crtc_sel, n_crtc_sel;
    logic [7:0] r_rom_sel, n_rom_sel;
    logic [7:0] r_crtc_reg [16];
    logic [7:0] n_crtc_reg [16];

    // next state and result
    always_comb begin
        logic [bsmo_pkg::MEM_AW-1:0] off;
        logic                        io_wr;
        logic                        io_rise;
        logic                        crtc_hit;
        bsmo_pkg::t_result           res;
        bsmo_pkg::t_mem_wr           ram_wr;
        bsmo_pkg::t_mem_wr           rom_wr;

        off          = i_item.address[bsmo_pkg::MEM_AW-1:0];
        crtc_hit     = (off[bsmo_pkg::MEM_AW-1:4] == bsmo_pkg::CELL_CRTC_REG[bsmo_pkg::MEM_AW-1:4]);
        io_wr        = i_item.io_request && !i_item.opcode_fetch && i_item.write_strobe;
        io_rise      = io_wr && !r_last_io_wr;
        res          = '0;
        ram_wr       = '0;
        rom_wr       = '0;
        n_paged      = r_paged;
        n_hidden     = r_hidden;
        n_freeze     = r_freeze;
        n_last_io_wr = r_last_io_wr;
        n_nmi_left   = r_nmi_left;
        n_pen        = r_pen;
        n_ink        = r_ink;
        n_ga_cfg     = r_ga_cfg;
        n_ram_cfg    = r_ram_cfg;
        n_crtc_sel   = r_crtc_sel;
        n_rom_sel    = r_rom_sel;
        n_crtc_reg   = r_crtc_reg;

        if (i_plugged) begin
            unique case (i_item.opcode)
                bsmo_pkg::OP_STOP: begin
                    // stop press pages in and starts a freeze session when not yet paged
                    if (!r_paged) begin
                        n_paged    = 1'b1;
                        n_freeze   = 1'b1;
                        n_nmi_left = bsmo_pkg::NMI_W'(bsmo_pkg::NMI_HOLD_CYCLES);
                    end
                end
                bsmo_pkg::OP_LOAD: begin
                    // rom load byte
                    if (i_item.address[15:bsmo_pkg::MEM_AW] == '0) begin
                        rom_wr.en   = 1'b1;
                        rom_wr.addr = off;
                        rom_wr.data = i_item.data_in;
                    end
                end
                bsmo_pkg::OP_BUS: begin
                    // machine reset drops paging first
                    if (i_item.machine_reset) begin
                        n_hidden = 1'b0;
                        n_paged  = 1'b0;
                        n_freeze = 1'b0;
                    end

                    // nmi hold countdown
                    if (r_nmi_left != '0) begin
                        res.nmi_drive = 1'b1;
                        n_nmi_left    = r_nmi_left - 1'b1;
                    end

                    n_last_io_wr = io_wr;

                    // rising edge of an i/o write: paging ports and shadows
                    if (io_rise) begin
                        if (i_item.address == bsmo_pkg::PORT_PAGE_IN) begin
                            if (!n_hidden) begin
                                n_paged = 1'b1;
                            end
                        end else if (i_item.address == bsmo_pkg::PORT_PAGE_OUT) begin
                            n_paged = 1'b0;
                            if (n_freeze) begin
                                n_freeze = 1'b0;
                                n_hidden = 1'b1;
                            end
                        end

                        if (i_item.address[15:14] == 2'b01) begin
                            unique case (i_item.data_in[7:6])
                                2'd0:    n_pen    = i_item.data_in;
                                2'd1:    n_ink    = i_item.data_in;
                                2'd2:    n_ga_cfg = i_item.data_in;
                                default: ;
                            endcase
                        end
                        if (!i_item.address[15] && (i_item.data_in[7:6] == 2'b11)) begin
                            n_ram_cfg = i_item.data_in;
                        end
                        if (!i_item.address[14]) begin
                            unique case (i_item.address[9:8])
                                2'd0:    n_crtc_sel = i_item.data_in;
                                2'd1:    n_crtc_reg[r_crtc_sel[3:0]] = i_item.data_in;
                                default: ;
                            endcase
                        end
                        if (!i_item.address[13]) begin
                            n_rom_sel = i_item.data_in;
                        end
                    end

                    if (n_paged) begin
                        // memory read below 4000 served by the overlay
                        if (i_item.memory_request && i_item.read_strobe && !i_item.refresh
                            && (i_item.address[15:14] == 2'b00)) begin
                            res.rom_disable = 1'b1;
                            res.data_valid  = 1'b1;
                            if (!i_item.address[13]) begin
                                res.data_out = ({1'b0, off} < i_rom_length) ? i_rom_q : 8'hFF;
                            end else begin
                                res.ram_disable = 1'b1;
                                priority if (off == bsmo_pkg::CELL_PEN) begin
                                    res.data_out = n_pen;
                                end else if (off == bsmo_pkg::CELL_INK) begin
                                    res.data_out = n_ink;
                                end else if (off == bsmo_pkg::CELL_GA_CFG) begin
                                    res.data_out = n_ga_cfg;
                                end else if (off == bsmo_pkg::CELL_RAM_CFG) begin
                                    res.data_out = n_ram_cfg;
                                end else if (off == bsmo_pkg::CELL_CRTC_SEL) begin
                                    res.data_out = n_crtc_sel;
                                end else if (off == bsmo_pkg::CELL_ROM_SEL) begin
                                    res.data_out = n_rom_sel;
                                end else if (crtc_hit) begin
                                    res.data_out = n_crtc_reg[off[3:0]];
                                end else begin
                                    res.data_out = i_ram_q;
                                end
                            end
                        end

                        // memory write to 2000-3fff lands in the work ram
                        if (i_item.memory_request && i_item.write_strobe
                            && (i_item.address[15:13] == 3'b001)) begin
                            res.ram_disable = 1'b1;
                            priority if (off == bsmo_pkg::CELL_PEN) begin
                                n_pen = i_item.data_in;
                            end else if (off == bsmo_pkg::CELL_INK) begin
                                n_ink = i_item.data_in;
                            end else if (off == bsmo_pkg::CELL_GA_CFG) begin
                                n_ga_cfg = i_item.data_in;
                            end else if (off == bsmo_pkg::CELL_RAM_CFG) begin
                                n_ram_cfg = i_item.data_in;
                            end else if (off == bsmo_pkg::CELL_CRTC_SEL) begin
                                n_crtc_sel = i_item.data_in;
                            end else if (off == bsmo_pkg::CELL_ROM_SEL) begin
                                n_rom_sel = i_item.data_in;
                            end else if (crtc_hit) begin
                                n_crtc_reg[off[3:0]] = i_item.data_in;
                            end else begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = off;
                                ram_wr.data = i_item.data_in;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        o_result   = res;
        o_ram_wr   = ram_wr;
        o_rom_wr   = rom_wr;
        o_ram_wr.en = ram_wr.en && i_adv;
        o_rom_wr.en = rom_wr.en && i_adv;
    end

    // state registers, updated as each beat leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paged      <= 1'b0;
            r_hidden     <= 1'b0;
            r_freeze     <= 1'b0;
            r_last_io_wr <= 1'b0;
            r_nmi_left   <= '0;
            r_pen        <= '0;
            r_ink        <= '0;
            r_ga_cfg     <= '0;
            r_ram_cfg    <= '0;
            r_crtc_sel   <= '0;
            r_rom_sel    <= '0;
            for (int k = 0; k < 16; k++) begin
                r_crtc_reg[k] <= '0;
            end
        end else if (i_adv) begin
            r_paged      <= n_paged;
            r_hidden     <= n_hidden;
            r_freeze     <= n_freeze;
            r_last_io_wr <= n_last_io_wr;
            r_nmi_left   <= n_nmi_left;
            r_pen        <= n_pen;
            r_ink        <= n_ink;
            r_ga_cfg     <= n_ga_cfg;
            r_ram_cfg    <= n_ram_cfg;
            r_crtc_sel   <= n_crtc_sel;
            r_rom_sel    <= n_rom_sel;
            r_crtc_reg   <= n_crtc_reg;
        end
    end

endmodule

[rtl/core/bus_snoop_memory_overlay_top.sv]
// ----------------------------------------------------------------------------
// bus_snoop_memory_overlay_top: bus-watching overlay cartridge
// Input register, engine, result register, work ram and overlay rom.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one beat per bus cycle,
//   stop press or rom load byte; output channel (o_out_valid / i_out_stall)
//   returns exactly one result beat per input beat, in order.
//   The result beat is ready once its input beat has passed the input
//   register and the output register was free to take it: the memories are
//   read as the beat is taken into the input register, and the engine
//   forms the result into the output register. Throughput is one beat per
//   cycle unless the receiver or the clearing pass stalls, set by the single
//   registered pass through the engine and the registered memory ports.
//   When the receiver stalls, the output register holds its beat and the
//   input register holds one more; the input side stalls only when both
//   are full or the work ram clearing pass runs.
//   After reset the work ram is cleared by a pass over all 8192 bytes, one byte
//   a cycle; the input channel stalls for that time while configuration
//   writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken as usual.
//   The user must change configuration only while no beat is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module bus_snoop_memory_overlay_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [bsmo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [15:0]                       i_address,
    input  logic [7:0]                        i_data_in,
    input  logic                              i_machine_reset,
    input  logic                              i_io_request,
    input  logic                              i_opcode_fetch,
    input  logic                              i_write_strobe,
    input  logic                              i_read_strobe,
    input  logic                              i_memory_request,
    input  logic                              i_refresh,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_nmi_drive,
    output logic                              o_rom_disable,
    output logic                              o_ram_disable,
    output logic                              o_data_valid,
    output logic [7:0]                        o_data_out
);

    logic                                r_plugged;
    logic [bsmo_pkg::ROM_LEN_W-1:0]      r_rom_length;
    logic                                r_clr_busy;
    logic [bsmo_pkg::MEM_AW-1:0]         r_clr_addr;
    bsmo_pkg::t_item                     r_in;
    logic                                r_in_valid;
    bsmo_pkg::t_result                   r_out;
    logic                                r_out_valid;

    bsmo_pkg::t_item                     in_item;
    bsmo_pkg::t_result                   eng_result;
    bsmo_pkg::t_mem_wr                   eng_ram_wr;
    bsmo_pkg::t_mem_wr                   eng_rom_wr;
    bsmo_pkg::t_mem_wr                   ram_wr;
    logic [7:0]                          ram_q;
    logic [7:0]                          rom_q;
    logic                                adv;
    logic                                in_take;

    // pipeline handshake
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_in_valid && !adv);
    assign in_take    = i_in_valid && !o_in_stall;

    assign in_item = '{
        opcode:         i_opcode,
        address:        i_address,
        data_in:        i_data_in,
        machine_reset:  i_machine_reset,
        io_request:     i_io_request,
        opcode_fetch:   i_opcode_fetch,
        write_strobe:   i_write_strobe,
        read_strobe:    i_read_strobe,
        memory_request: i_memory_request,
        refresh:        i_refresh
    };

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plugged    <= 1'b0;
            r_rom_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsmo_pkg::CFG_PLUGGED:    r_plugged <= i_cfg_data[0];
                bsmo_pkg::CFG_ROM_LENGTH: begin
                    if (i_cfg_data > bsmo_pkg::CFG_DATA_W'(bsmo_pkg::ROM_BYTES)) begin
                        r_rom_length <= bsmo_pkg::ROM_LEN_W'(bsmo_pkg::ROM_BYTES);
                    end else begin
                        r_rom_length <= i_cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // work ram clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == bsmo_pkg::MEM_AW'(bsmo_pkg::RAM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = r_clr_addr;
            ram_wr.data = '0;
        end else begin
            ram_wr = eng_ram_wr;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= eng_result;
        end
    end

    bsmo_ram u_work_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_take),
        .i_rd_addr (i_address[bsmo_pkg::MEM_AW-1:0]),
        .i_wr      (ram_wr),
        .o_rd_data (ram_q)
    );

    bsmo_ram u_overlay_rom (
        .i_clk     (i_clk),
        .i_rd_en   (in_take),
        .i_rd_addr (i_address[bsmo_pkg::MEM_AW-1:0]),
        .i_wr      (eng_rom_wr),
        .o_rd_data (rom_q)
    );

    bsmo_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_item       (r_in),
        .i_ram_q      (ram_q),
        .i_rom_q      (rom_q),
        .i_plugged    (r_plugged),
        .i_rom_length (r_rom_length),
        .o_result     (eng_result),
        .o_ram_wr     (eng_ram_wr),
        .o_rom_wr     (eng_rom_wr)
    );

    assign o_out_valid   = r_out_valid;
    assign o_nmi_drive   = r_out.nmi_drive;
    assign o_rom_disable = r_out.rom_disable;
    assign o_ram_disable = r_out.ram_disable;
    assign o_data_valid  = r_out.data_valid;
    assign o_data_out    = r_out.data_out;

endmodule
